[rtl/core/dai_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dai_pkg
// Shared types and constants for the checked decimal ASCII parser.
// ----------------------------------------------------------------------------
package dai_pkg;

    localparam int VAL_W   = 64;
    localparam int CH_W    = 8;
    localparam int DIG_W   = 4;
    localparam int MAG32_W = 32;

    // classified-character queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // result queue at the back end
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // mode register codes
    localparam logic MODE_S32 = 1'b0;
    localparam logic MODE_U64 = 1'b1;

    // ASCII codes
    localparam logic [CH_W-1:0] CH_HT    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SP    = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    // limit / 10 and limit % 10 per mode
    localparam logic [VAL_W-1:0] LIM10_S32 = 64'd214748364;
    localparam logic [VAL_W-1:0] LIM10_U64 = 64'd1844674407370955161;
    localparam logic [DIG_W-1:0] LAST_POS  = 4'd7;
    localparam logic [DIG_W-1:0] LAST_NEG  = 4'd8;
    localparam logic [DIG_W-1:0] LAST_U64  = 4'd5;

    typedef enum logic [2:0] {
        CL_SPACE = 3'd0,
        CL_PLUS  = 3'd1,
        CL_MINUS = 3'd2,
        CL_DIGIT = 3'd3,
        CL_OTHER = 3'd4
    } t_cls;

    typedef struct packed {
        logic             mode;
        logic             first;
        t_cls             cls;
        logic [DIG_W-1:0] digit;
    } t_cls_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_cq_stat;

endpackage

[rtl/core/decimal_ascii_to_int_checked.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_ascii_to_int_checked
// Checked ASCII decimal to integer parser, one character per transaction.
// ----------------------------------------------------------------------------
// Feed one character per push transaction; i_first marks the first character
// of each string. Leading whitespace (space, HT..CR) is skipped, then in
// signed mode (mode 0) one optional '+' or '-' is taken, and in unsigned mode
// (mode 1) '+' is skipped like whitespace. Digits accumulate with a range
// check: signed 32-bit (-2147483648 is accepted) or unsigned 64-bit. The first
// non-digit, including the 0 terminator, produces one result transaction;
// a digit that would overflow produces a result at once with o_overflow set
// and the partial magnitude (masked to 32 bits in signed mode). Characters
// after a result are dropped until the next i_first. Signed results are 32-bit
// two's complement, zero-extended to 64 bits. A string with no digits gives 0.
// Throughput is one character per clock while the result queue has room; the
// back end multiplies by ten (shift and add) combinationally, with the limit
// compare in parallel. Results pass the character queue, then the result queue.
// full rises only when results are left unpopped long enough to fill the
// two-entry result queue and the two-entry character queue behind it. The mode
// register is written through the cfg channel (always ready) and should only
// change while no transaction is in flight.
// ----------------------------------------------------------------------------
module decimal_ascii_to_int_checked (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // character channel
    input  logic                          push,
    output logic                          full,
    input  logic [dai_pkg::CH_W-1:0]      i_ch,
    input  logic                          i_first,
    // result channel
    output logic                          empty,
    input  logic                          pop,
    output logic [dai_pkg::VAL_W-1:0]     o_value,
    output logic                          o_overflow,
    // mode register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_mode
);
    import dai_pkg::*;

    t_cls_item front_item;
    t_cls_item back_item;
    t_cq_stat  cq_stat;
    logic      back_take;

    assign o_cfg_ready = 1'b1;
    assign full        = cq_stat.full;

    // front: mode register and character classification
    dai_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ch        (i_ch),
        .i_first     (i_first),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_mode  (i_cfg_mode),
        .o_item      (front_item)
    );

    // decouples the classifier from the parse state so each side stalls alone
    dai_cq u_cq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (back_take),
        .o_item  (back_item),
        .o_stat  (cq_stat)
    );

    // back: parse state machine, accumulation and result queue
    dai_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!cq_stat.empty),
        .i_item     (back_item),
        .o_take     (back_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_value    (o_value),
        .o_overflow (o_overflow)
    );

endmodule

[rtl/core/dai_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dai_front
// Mode register and character classifier; builds one queue entry per char.
// ----------------------------------------------------------------------------
module dai_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dai_pkg::CH_W-1:0]      i_ch,
    input  logic                          i_first,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_mode,
    output dai_pkg::t_cls_item            o_item
);
    import dai_pkg::*;

    logic r_mode;
    logic n_mode;
    t_cls cls;

    assign n_mode = i_cfg_valid ? i_cfg_mode : r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_S32;
        end else begin
            r_mode <= n_mode;
        end
    end

    always_comb begin
        unique case (i_ch) inside
            CH_SP, [CH_HT:CH_CR]: cls = CL_SPACE;
            CH_PLUS:              cls = CL_PLUS;
            CH_MINUS:             cls = CL_MINUS;
            [CH_ZERO:CH_NINE]:    cls = CL_DIGIT;
            default:              cls = CL_OTHER;
        endcase
    end

    always_comb begin
        o_item.mode  = r_mode;
        o_item.first = i_first;
        o_item.cls   = cls;
        o_item.digit = DIG_W'(i_ch - CH_ZERO);
    end

endmodule

[rtl/core/dai_cq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dai_cq
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module dai_cq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dai_pkg::t_cls_item   i_item,
    input  logic                 i_pop,
    output dai_pkg::t_cls_item   o_item,
    output dai_pkg::t_cq_stat    o_stat
);
    import dai_pkg::*;

    t_cls_item        r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp, n_wp;
    logic [CQ_AW-1:0] r_rp, n_rp;
    logic [CQ_CW-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[rtl/core/dai_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dai_back
// Parse state, digit accumulation with limit check, and the result queue.
// ----------------------------------------------------------------------------
module dai_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  dai_pkg::t_cls_item         i_item,
    output logic                       o_take,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [dai_pkg::VAL_W-1:0]  o_value,
    output logic                       o_overflow
);
    import dai_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic               r_neg, n_neg;

    t_phase             e_phase;
    logic [VAL_W-1:0]   e_acc;
    logic               e_neg;
    logic [VAL_W-1:0]   lim10;
    logic [DIG_W-1:0]   lastmax;
    logic               dig_ovf;
    logic [VAL_W-1:0]   acc10;
    logic [MAG32_W-1:0] fin_s;
    logic [VAL_W-1:0]   fin_val;
    logic [VAL_W-1:0]   ovf_val;
    logic               emit;
    logic [VAL_W-1:0]   emit_val;
    logic               emit_ovf;
    logic               run;

    // result queue
    logic [VAL_W-1:0]   r_oq_val [OQ_DEPTH];
    logic               r_oq_ovf [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_oq_wp, n_oq_wp;
    logic [OQ_AW-1:0]   r_oq_rp, n_oq_rp;
    logic [OQ_CW-1:0]   r_oq_cnt, n_oq_cnt;
    logic               oq_push;
    logic               oq_pop;

    assign run    = i_valid && (r_oq_cnt != OQ_CW'(OQ_DEPTH));
    assign o_take = run;

    // a new string clears the state before the character is handled
    always_comb begin
        e_phase = i_item.first ? PH_LEAD : r_phase;
        e_acc   = i_item.first ? '0 : r_acc;
        e_neg   = i_item.first ? 1'b0 : r_neg;
    end

    always_comb begin
        lim10   = (i_item.mode == MODE_U64) ? LIM10_U64 : LIM10_S32;
        lastmax = (i_item.mode == MODE_U64) ? LAST_U64 :
                  (e_neg ? LAST_NEG : LAST_POS);
        dig_ovf = (e_acc > lim10) || ((e_acc == lim10) && (i_item.digit > lastmax));
        acc10   = (e_acc << 3) + (e_acc << 1) + VAL_W'(i_item.digit);
        fin_s   = e_neg ? (~e_acc[MAG32_W-1:0] + 1'b1) : e_acc[MAG32_W-1:0];
        fin_val = (i_item.mode == MODE_U64) ? e_acc : VAL_W'(fin_s);
        ovf_val = (i_item.mode == MODE_U64) ? e_acc : VAL_W'(e_acc[MAG32_W-1:0]);
    end

    always_comb begin
        n_phase  = e_phase;
        n_acc    = e_acc;
        n_neg    = e_neg;
        emit     = 1'b0;
        emit_val = fin_val;
        emit_ovf = 1'b0;
        unique case (e_phase)
            PH_LEAD, PH_DIGITS: begin
                if (i_item.cls == CL_DIGIT) begin
                    if (dig_ovf) begin
                        emit     = 1'b1;
                        emit_val = ovf_val;
                        emit_ovf = 1'b1;
                        n_phase  = PH_DONE;
                    end else begin
                        n_acc   = acc10;
                        n_phase = PH_DIGITS;
                    end
                end else if (e_phase == PH_LEAD && i_item.cls == CL_SPACE) begin
                    n_phase = PH_LEAD;
                end else if (e_phase == PH_LEAD && i_item.cls == CL_PLUS &&
                             i_item.mode == MODE_U64) begin
                    n_phase = PH_LEAD;
                end else if (e_phase == PH_LEAD && i_item.mode == MODE_S32 &&
                             (i_item.cls == CL_PLUS || i_item.cls == CL_MINUS)) begin
                    n_neg   = (i_item.cls == CL_MINUS);
                    n_phase = PH_DIGITS;
                end else begin
                    emit    = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = e_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (run) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
        end
    end

    // result queue
    assign o_empty    = (r_oq_cnt == '0);
    assign oq_push    = run && emit;
    assign oq_pop     = i_pop && !o_empty;
    assign o_value    = r_oq_val[r_oq_rp];
    assign o_overflow = r_oq_ovf[r_oq_rp];

    always_comb begin
        n_oq_wp  = r_oq_wp;
        n_oq_rp  = r_oq_rp;
        n_oq_cnt = r_oq_cnt;
        if (oq_push) begin
            n_oq_wp = (r_oq_wp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_oq_wp + 1'b1;
        end
        if (oq_pop) begin
            n_oq_rp = (r_oq_rp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_oq_rp + 1'b1;
        end
        if (oq_push && !oq_pop) begin
            n_oq_cnt = r_oq_cnt + 1'b1;
        end else if (!oq_push && oq_pop) begin
            n_oq_cnt = r_oq_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            r_oq_wp  <= n_oq_wp;
            r_oq_rp  <= n_oq_rp;
            r_oq_cnt <= n_oq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq_val[r_oq_wp] <= emit_val;
            r_oq_ovf[r_oq_wp] <= emit_ovf;
        end
    end

endmodule

[rtl/core/dai_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dai_chk
// Port-level checks for the parser, bound to the top level.
// ----------------------------------------------------------------------------
module dai_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [dai_pkg::VAL_W-1:0]     o_value,
    input logic                          o_overflow
);

    // both queues come out of reset empty
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // with no result pending the back end drains a character every cycle,
    // so the input side cannot fill up
    a_no_full_while_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(empty) |-> !full)
        else $error("input full while result queue was empty");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_value) && $stable(o_overflow))
        else $error("pending result changed before pop");

    // a character accepted while no result is pending leaves the input side not full
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full && empty |=> !full)
        else $error("input full right after one transaction");

endmodule

bind decimal_ascii_to_int_checked dai_chk u_dai_chk (.*);
